// ----- design/cfl_pkg.sv -----
`default_nettype none

package cfl_pkg;

   localparam int FIELD_W        = 6;
   localparam int MAX_FIELDS_DEF = 58;
   localparam logic [FIELD_W-1:0] FIELD_COUNT_RST = 6'd13;

   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'h1021;
   localparam logic [15:0] CRC_TOP    = 16'h8000;
   localparam logic [15:0] SOF_MARK   = 16'h55AA;
   localparam logic [15:0] EOF_MARK   = 16'hAA55;
   localparam logic [15:0] DLEN_BASE  = 16'd10;

   typedef struct packed {
      logic [31:0] timestamp;
      logic [15:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       run_last;
      logic       frame_last;
   } rsp_type;

   // one accepted word plus the frame context decided at acceptance
   typedef struct packed {
      logic [31:0] timestamp;
      logic [15:0] value;
      logic [15:0] dlen;
      logic        first;
      logic        last;
   } item_type;

   // byte positions within the bytes one word can produce
   typedef enum logic [3:0] {
      POS_SOF_LO  = 4'd0,
      POS_SOF_HI  = 4'd1,
      POS_DLEN_LO = 4'd2,
      POS_DLEN_HI = 4'd3,
      POS_TS_0    = 4'd4,
      POS_TS_1    = 4'd5,
      POS_TS_2    = 4'd6,
      POS_TS_3    = 4'd7,
      POS_VAL_LO  = 4'd8,
      POS_VAL_HI  = 4'd9,
      POS_CRC_LO  = 4'd10,
      POS_CRC_HI  = 4'd11,
      POS_EOF_LO  = 4'd12,
      POS_EOF_HI  = 4'd13
   } pos_type;

   // CRC-16/CCITT-FALSE, one byte, MSB first
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- design/cfl_emitter.sv -----
`default_nettype none

module cfl_emitter
   import cfl_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     load,
   input  wire item_type item,
   output logic          ready,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output rsp_type       rsp_data
);

   item_type    item_ff, item_in;
   logic        item_valid_ff, item_valid_in;
   pos_type     pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        emit;
   logic        at_end;
   logic        feed;
   logic [7:0]  byte_sel;

   always_comb begin
      emit   = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
      at_end = (pos_ff == (item_ff.last ? POS_EOF_HI : POS_VAL_HI));
      feed   = (pos_ff >= POS_DLEN_LO) && (pos_ff <= POS_VAL_HI);
      ready  = !item_valid_ff || (emit && at_end);

      unique case (pos_ff)
         POS_SOF_LO:  byte_sel = SOF_MARK[7:0];
         POS_SOF_HI:  byte_sel = SOF_MARK[15:8];
         POS_DLEN_LO: byte_sel = item_ff.dlen[7:0];
         POS_DLEN_HI: byte_sel = item_ff.dlen[15:8];
         POS_TS_0:    byte_sel = item_ff.timestamp[7:0];
         POS_TS_1:    byte_sel = item_ff.timestamp[15:8];
         POS_TS_2:    byte_sel = item_ff.timestamp[23:16];
         POS_TS_3:    byte_sel = item_ff.timestamp[31:24];
         POS_VAL_LO:  byte_sel = item_ff.value[7:0];
         POS_VAL_HI:  byte_sel = item_ff.value[15:8];
         POS_CRC_LO:  byte_sel = crc_ff[7:0];
         POS_CRC_HI:  byte_sel = crc_ff[15:8];
         POS_EOF_LO:  byte_sel = EOF_MARK[7:0];
         POS_EOF_HI:  byte_sel = EOF_MARK[15:8];
         default:     byte_sel = 8'h00;
      endcase

      item_in       = item_ff;
      item_valid_in = item_valid_ff;
      pos_in        = pos_ff;
      crc_in        = crc_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;

      if (emit) begin
         rsp_valid_in       = 1'b1;
         rsp_in.data_byte   = byte_sel;
         rsp_in.run_last    = at_end;
         rsp_in.frame_last  = at_end && item_ff.last;
         if (pos_ff == POS_SOF_LO) begin
            crc_in = CRC_INIT;
         end else if (feed) begin
            crc_in = crc_feed(crc_ff, byte_sel);
         end
         if (at_end) begin
            item_valid_in = 1'b0;
         end else begin
            pos_in = pos_type'(pos_ff + 4'd1);
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // a new word takes the slot as the old one drains
      if (load) begin
         item_in       = item;
         item_valid_in = 1'b1;
         pos_in        = item.first ? POS_SOF_LO : POS_VAL_LO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         pos_ff        <= POS_VAL_LO;
         crc_ff        <= CRC_INIT;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         pos_ff        <= pos_in;
         crc_ff        <= crc_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_frame_last_is_eof: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.frame_last |->
         rsp_ff.run_last && (rsp_ff.data_byte == EOF_MARK[15:8]))
      else $error("frame_last on a byte other than the closing flag");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff |-> (pos_ff <= POS_EOF_HI))
      else $error("byte position beyond end of frame");

   a_crc_restart: assert property (@(posedge clock) disable iff (reset)
      emit && (pos_ff == POS_SOF_LO) |=> (crc_ff == CRC_INIT))
      else $error("CRC not restarted at start flag");

   a_load_when_ready: assert property (@(posedge clock) disable iff (reset)
      load |-> ready)
      else $error("word loaded while slot busy");

endmodule

`default_nettype wire

// ----- design/crc16_framed_log_serializer.sv -----
// An accepted word is held in a word slot; its bytes then pass through the output register.
// Throughput: one byte per cycle while rsp_stall is low, from the single output byte
//   register; a middle field is 2 bytes, a first field 10, a last 6, a one-field frame 14.
// A new word is accepted in the cycle its predecessor's last byte enters the output register.
// Reset (synchronous, active high): empties both stages, field count back to 13,
//   field index to 0, CRC to FFFF.
`default_nettype none

module crc16_framed_log_serializer
   import cfl_pkg::*;
#(
   parameter int MAX_FIELDS = MAX_FIELDS_DEF
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire req_type            req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output rsp_type                 rsp_data,
   input  wire logic               csr_wr_en,
   input  wire logic [FIELD_W-1:0] csr_wr_data
);

   localparam logic [FIELD_W-1:0] MaxCnt = FIELD_W'(MAX_FIELDS);

   // field count register, latched into the frame at its first word
   logic [FIELD_W-1:0] field_count_ff, field_count_in;
   // frame progress
   logic [FIELD_W-1:0] field_index_ff, field_index_in;
   logic [FIELD_W-1:0] frame_len_ff, frame_len_in;

   logic               accept;
   logic               ready;
   logic               first;
   logic [FIELD_W-1:0] cnt_sat;
   logic [FIELD_W-1:0] len;
   logic [FIELD_W-1:0] idx_next;
   item_type           item;

   always_comb begin
      accept = req_valid && ready;
      first  = (field_index_ff == '0);

      // clamp the programmed count to 1..MAX_FIELDS
      priority if (field_count_ff == '0) begin
         cnt_sat = FIELD_W'(1);
      end else if (field_count_ff > MaxCnt) begin
         cnt_sat = MaxCnt;
      end else begin
         cnt_sat = field_count_ff;
      end

      len      = first ? cnt_sat : frame_len_ff;
      idx_next = field_index_ff + FIELD_W'(1);

      item.timestamp = req_data.timestamp;
      item.value     = req_data.value;
      item.dlen      = DLEN_BASE + 16'({len, 1'b0});
      item.first     = first;
      item.last      = (idx_next >= len);

      field_count_in = csr_wr_en ? csr_wr_data : field_count_ff;
      field_index_in = field_index_ff;
      frame_len_in   = frame_len_ff;
      if (accept) begin
         frame_len_in   = len;
         // wrap to zero after the frame's last field
         field_index_in = item.last ? '0 : idx_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_count_ff <= FIELD_COUNT_RST;
         field_index_ff <= '0;
         frame_len_ff   <= FIELD_COUNT_RST;
      end else begin
         field_count_ff <= field_count_in;
         field_index_ff <= field_index_in;
         frame_len_ff   <= frame_len_in;
      end
   end

   // hold the word, walk its bytes, run the CRC, drive the output register
   cfl_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .item      (item),
      .ready     (ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign req_stall = !ready;

   a_index_in_frame: assert property (@(posedge clock) disable iff (reset)
      (field_index_ff != '0) |-> (field_index_ff < frame_len_ff))
      else $error("field index past frame length");

   a_frame_len_range: assert property (@(posedge clock) disable iff (reset)
      accept |=> (frame_len_ff != '0) && (frame_len_ff <= MaxCnt))
      else $error("frame length outside 1..MAX_FIELDS");

   a_first_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && item.last |=> (field_index_ff == '0))
      else $error("field index not cleared after last field");

endmodule

`default_nettype wire
